/* sv/key_press_duration_classifier_top_defines.svh */
// Assertion macros shared by the key press classifier RTL.
`ifndef KEY_PRESS_DURATION_CLASSIFIER_TOP_DEFINES_SVH
`define KEY_PRESS_DURATION_CLASSIFIER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define KPD_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("kpd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KPD_ASSERT_NXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("kpd assertion failed");

`else

`define KPD_ASSERT_IMP(name, clk, rst_n, pre, post)
`define KPD_ASSERT_NXT(name, clk, rst_n, pre, post)

`endif

`endif

/* sv/kpd_pkg.sv */
// Shared types, widths and codes for the key press duration classifier.
`default_nettype none

package kpd_pkg;

    // Default key count and per-scan event limit
    localparam int NUM_KEYS_DEF = 4;
    localparam int MAX_EVENTS   = 8;
    localparam int CNT_W        = 4;

    // Field widths
    localparam int TICK_W     = 10;
    localparam int MS_W       = 16;
    localparam int DUR_W      = 32;
    localparam int PROD_W     = DUR_W + TICK_W;
    localparam int KEY_IDX_W  = 2;
    localparam int EVT_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUPER_LONG  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_KEY   = 3'd5;

    // Configuration reset values
    localparam logic [TICK_W-1:0]    TICK_PERIOD_RST = 10'd10;
    localparam logic [MS_W-1:0]      DEBOUNCE_RST    = 16'd10;
    localparam logic [MS_W-1:0]      SHORT_MAX_RST   = 16'd500;
    localparam logic [MS_W-1:0]      LONG_RST        = 16'd800;
    localparam logic [MS_W-1:0]      SUPER_LONG_RST  = 16'd2000;
    localparam logic [KEY_IDX_W-1:0] POWER_KEY_RST   = 2'd0;

    // Event type codes
    localparam logic [EVT_W-1:0] EVT_SHORT = 2'd0;
    localparam logic [EVT_W-1:0] EVT_LONG  = 2'd1;
    localparam logic [EVT_W-1:0] EVT_SUPER = 2'd2;

    // Input item kinds
    localparam logic KIND_LEVEL = 1'b0;
    localparam logic KIND_SCAN  = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [KEY_IDX_W-1:0]  key_index;
        logic                  pin_level;
        logic [DUR_W-1:0]      now_ticks;
    } kpd_in_t;

    typedef struct packed {
        logic [KEY_IDX_W-1:0]  event_key;
        logic [EVT_W-1:0]      event_type;
        logic                  last;
    } kpd_out_t;

    // Duration thresholds handed to the compare unit
    typedef struct packed {
        logic [MS_W-1:0] bounce_ms;
        logic [MS_W-1:0] short_max_ms;
        logic [MS_W-1:0] long_ms;
        logic [MS_W-1:0] xlong_ms;
    } kpd_thr_t;

    // Threshold compare results for the current duration
    typedef struct packed {
        logic ge_debounce;
        logic lt_short_max;
        logic ge_long;
        logic ge_super;
    } kpd_cmp_t;

    // Sequencer request to the output stage
    typedef struct packed {
        logic                  push;
        logic                  flush;
        logic [KEY_IDX_W-1:0]  ev_key;
        logic [EVT_W-1:0]      ev_type;
    } kpd_oreq_t;

    // Output stage status back to the sequencer
    typedef struct packed {
        logic push_ready;
        logic flush_done;
        logic pend_valid;
    } kpd_ost_t;

endpackage

`default_nettype wire

/* sv/kpd_dur_unit.sv */
// Shared duration unit: tick difference, scale by tick period, threshold compares.
`default_nettype none

module kpd_dur_unit (
    input  wire logic                         aclk,
    input  wire logic                         diff_en,
    input  wire logic                         mul_en,
    input  wire logic [kpd_pkg::DUR_W-1:0]    now_ticks,
    input  wire logic [kpd_pkg::DUR_W-1:0]    start_ticks,
    input  wire logic [kpd_pkg::TICK_W-1:0]   tick_period,
    input  wire kpd_pkg::kpd_thr_t            thr,
    output      kpd_pkg::kpd_cmp_t            cmp
);
    import kpd_pkg::*;

    logic [DUR_W-1:0]  diff_reg;
    logic [DUR_W-1:0]  diff_next;
    logic [DUR_W-1:0]  dur_reg;
    logic [DUR_W-1:0]  dur_next;
    logic [PROD_W-1:0] prod;

    // Step one: elapsed ticks, wraps modulo 2^32
    assign diff_next = now_ticks - start_ticks;

    // Step two: ticks to milliseconds, low 32 bits kept
    assign prod     = PROD_W'(diff_reg) * PROD_W'(tick_period);
    assign dur_next = prod[DUR_W-1:0];

    always_ff @(posedge aclk) begin
        if (diff_en) begin
            diff_reg <= diff_next;
        end
        if (mul_en) begin
            dur_reg <= dur_next;
        end
    end

    // Threshold compares on the registered duration
    assign cmp.ge_debounce  = (dur_reg >= DUR_W'(thr.bounce_ms));
    assign cmp.lt_short_max = (dur_reg <  DUR_W'(thr.short_max_ms));
    assign cmp.ge_long      = (dur_reg >= DUR_W'(thr.long_ms));
    assign cmp.ge_super     = (dur_reg >= DUR_W'(thr.xlong_ms));

endmodule

`default_nettype wire

/* sv/kpd_out_stage.sv */
// Event output stage: one held-back event for the last flag plus the output register.
`default_nettype none

module kpd_out_stage (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire kpd_pkg::kpd_oreq_t  req,
    output      kpd_pkg::kpd_ost_t   st,
    output      logic                m_valid,
    input  wire logic                m_ready,
    output      kpd_pkg::kpd_out_t   m_data
);
    import kpd_pkg::*;

    logic                 pend_valid_reg, pend_valid_next;
    logic [KEY_IDX_W-1:0] pend_key_reg, pend_key_next;
    logic [EVT_W-1:0]     pend_type_reg, pend_type_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 m_valid_reg, m_valid_next;
    kpd_out_t             m_data_reg, m_data_next;
    logic                 out_free;
    logic                 push_ready;
    logic                 flush_done;

    assign out_free = !m_valid_reg || m_ready;

    // The newest event is held back until the next one or the end of scan
    // tells whether it is the last one.
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_key_next   = pend_key_reg;
        pend_type_next  = pend_type_reg;
        cnt_next        = cnt_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        push_ready      = 1'b0;
        flush_done      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (req.push) begin
            if (cnt_reg == CNT_W'(MAX_EVENTS)) begin
                // over the per-scan limit: drop
                push_ready = 1'b1;
            end else if (!pend_valid_reg) begin
                pend_valid_next = 1'b1;
                pend_key_next   = req.ev_key;
                pend_type_next  = req.ev_type;
                cnt_next        = cnt_reg + 1'b1;
                push_ready      = 1'b1;
            end else if (out_free) begin
                m_data_next.event_key  = pend_key_reg;
                m_data_next.event_type = pend_type_reg;
                m_data_next.last       = 1'b0;
                m_valid_next           = 1'b1;
                pend_key_next          = req.ev_key;
                pend_type_next         = req.ev_type;
                cnt_next               = cnt_reg + 1'b1;
                push_ready             = 1'b1;
            end
        end else if (req.flush) begin
            if (!pend_valid_reg) begin
                cnt_next   = '0;
                flush_done = 1'b1;
            end else if (out_free) begin
                m_data_next.event_key  = pend_key_reg;
                m_data_next.event_type = pend_type_reg;
                m_data_next.last       = 1'b1;
                m_valid_next           = 1'b1;
                pend_valid_next        = 1'b0;
                cnt_next               = '0;
                flush_done             = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        pend_key_reg  <= pend_key_next;
        pend_type_reg <= pend_type_next;
        m_data_reg    <= m_data_next;
    end

    assign st.push_ready = push_ready;
    assign st.flush_done = flush_done;
    assign st.pend_valid = pend_valid_reg;
    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;

endmodule

`default_nettype wire

/* sv/key_press_duration_classifier_top.sv */
// Key press duration classifier top: level changes, scan sequencer, key state.
// A level change is accepted back to back while idle.
// A scan runs the difference, multiply and compare steps of the shared duration
// unit for each key, then an emit step per event and a final flush; s_ready is
// low meanwhile and output stalls extend it.
// Synchronous active-low reset clears key state and restores register defaults.
`default_nettype none

`include "key_press_duration_classifier_top_defines.svh"

module key_press_duration_classifier_top #(
    parameter int NUM_KEYS = kpd_pkg::NUM_KEYS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output      logic                            s_ready,
    input  wire kpd_pkg::kpd_in_t                s_data,
    output      logic                            m_valid,
    input  wire logic                            m_ready,
    output      kpd_pkg::kpd_out_t               m_data,
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [kpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [kpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import kpd_pkg::*;

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int CMP_W = (KEY_W > KEY_IDX_W) ? KEY_W : KEY_IDX_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIFF  = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_EVAL  = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_FLUSH = 6'b100000
    } kpd_state_t;

    // Configuration registers
    logic [TICK_W-1:0]    tick_period_reg;
    logic [MS_W-1:0]      debounce_reg;
    logic [MS_W-1:0]      short_max_reg;
    logic [MS_W-1:0]      long_reg;
    logic [MS_W-1:0]      super_long_reg;
    logic [KEY_IDX_W-1:0] power_key_reg;

    // Per-key state
    logic [DUR_W-1:0] press_start_reg [NUM_KEYS];
    logic             is_pressed_reg  [NUM_KEYS];
    logic             long_fired_reg  [NUM_KEYS];

    // Sequencer
    kpd_state_t       state_reg, state_next;
    logic [KEY_W-1:0] key_cnt_reg, key_cnt_next;
    logic [DUR_W-1:0] now_reg;
    logic             q_long_reg, q_long_next;
    logic             q_super_reg, q_super_next;
    logic             q_short_reg, q_short_next;

    logic             s_fire;
    logic             lvl_fire;
    logic [KEY_W-1:0] lvl_idx;
    logic             key_last;
    logic             cur_pressed;
    logic             cur_fired;
    logic             cur_start_nz;
    logic             is_power;
    logic             ev_long, ev_super, ev_short;
    kpd_thr_t         thr;
    kpd_cmp_t         cmp;
    kpd_oreq_t        oreq;
    kpd_ost_t         ost;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign lvl_fire  = s_fire && (s_data.kind == KIND_LEVEL)
                       && (32'(s_data.key_index) < 32'(NUM_KEYS));
    assign lvl_idx   = KEY_W'(s_data.key_index);
    assign key_last  = (key_cnt_reg == KEY_W'(NUM_KEYS - 1));

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_period_reg <= TICK_PERIOD_RST;
            debounce_reg    <= DEBOUNCE_RST;
            short_max_reg   <= SHORT_MAX_RST;
            long_reg        <= LONG_RST;
            super_long_reg  <= SUPER_LONG_RST;
            power_key_reg   <= POWER_KEY_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TICK_PERIOD: tick_period_reg <= cfg_data[TICK_W-1:0];
                REG_DEBOUNCE:    debounce_reg    <= cfg_data[MS_W-1:0];
                REG_SHORT_MAX:   short_max_reg   <= cfg_data[MS_W-1:0];
                REG_LONG:        long_reg        <= cfg_data[MS_W-1:0];
                REG_SUPER_LONG:  super_long_reg  <= cfg_data[MS_W-1:0];
                REG_POWER_KEY:   power_key_reg   <= cfg_data[KEY_IDX_W-1:0];
                default: ;
            endcase
        end
    end

    assign thr.bounce_ms    = debounce_reg;
    assign thr.short_max_ms = short_max_reg;
    assign thr.long_ms      = long_reg;
    assign thr.xlong_ms     = super_long_reg;

    // Shared duration unit
    kpd_dur_unit u_dur (
        .aclk        (aclk),
        .diff_en     (state_reg == ST_DIFF),
        .mul_en      (state_reg == ST_MUL),
        .now_ticks   (now_reg),
        .start_ticks (press_start_reg[key_cnt_reg]),
        .tick_period (tick_period_reg),
        .thr         (thr),
        .cmp         (cmp)
    );

    // Classification of the key under scan
    assign cur_pressed  = is_pressed_reg[key_cnt_reg];
    assign cur_fired    = long_fired_reg[key_cnt_reg];
    assign cur_start_nz = (press_start_reg[key_cnt_reg] != '0);
    assign is_power     = (CMP_W'(key_cnt_reg) == CMP_W'(power_key_reg));
    assign ev_long      = cur_pressed && !cur_fired && cmp.ge_long;
    assign ev_super     = cur_pressed && is_power && cmp.ge_super;
    assign ev_short     = !cur_pressed && cur_start_nz && cmp.ge_debounce
                          && cmp.lt_short_max;

    // Requests to the output stage; long goes out before super-long
    always_comb begin
        oreq.push  = (state_reg == ST_EMIT);
        oreq.flush = (state_reg == ST_FLUSH);
        oreq.ev_key = KEY_IDX_W'(key_cnt_reg);
        if (q_long_reg) begin
            oreq.ev_type = EVT_LONG;
        end else if (q_super_reg) begin
            oreq.ev_type = EVT_SUPER;
        end else begin
            oreq.ev_type = EVT_SHORT;
        end
    end

    kpd_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (oreq),
        .st      (ost),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Scan sequencer
    always_comb begin
        state_next   = state_reg;
        key_cnt_next = key_cnt_reg;
        q_long_next  = q_long_reg;
        q_super_next = q_super_reg;
        q_short_next = q_short_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_data.kind == KIND_SCAN)) begin
                    key_cnt_next = '0;
                    state_next   = ST_DIFF;
                end
            end
            ST_DIFF: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                q_long_next  = ev_long;
                q_super_next = ev_super;
                q_short_next = ev_short;
                if (ev_long || ev_super || ev_short) begin
                    state_next = ST_EMIT;
                end else if (key_last) begin
                    state_next = ST_FLUSH;
                end else begin
                    key_cnt_next = key_cnt_reg + 1'b1;
                    state_next   = ST_DIFF;
                end
            end
            ST_EMIT: begin
                if (ost.push_ready) begin
                    if (q_long_reg) begin
                        q_long_next = 1'b0;
                    end else if (q_super_reg) begin
                        q_super_next = 1'b0;
                    end else begin
                        q_short_next = 1'b0;
                    end
                    // long with a super-long still to go stays here
                    if (!(q_long_reg && q_super_reg)) begin
                        if (key_last) begin
                            state_next = ST_FLUSH;
                        end else begin
                            key_cnt_next = key_cnt_reg + 1'b1;
                            state_next   = ST_DIFF;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (ost.flush_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            key_cnt_reg <= '0;
            q_long_reg  <= 1'b0;
            q_super_reg <= 1'b0;
            q_short_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            key_cnt_reg <= key_cnt_next;
            q_long_reg  <= q_long_next;
            q_super_reg <= q_super_next;
            q_short_reg <= q_short_next;
        end
    end

    // Scan timestamp
    always_ff @(posedge aclk) begin
        if (s_fire && (s_data.kind == KIND_SCAN)) begin
            now_reg <= s_data.now_ticks;
        end
    end

    // Key state: level changes while idle, classification updates in scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                press_start_reg[k] <= '0;
                is_pressed_reg[k]  <= 1'b0;
                long_fired_reg[k]  <= 1'b0;
            end
        end else if (lvl_fire) begin
            is_pressed_reg[lvl_idx] <= !s_data.pin_level;
            if (!s_data.pin_level) begin
                press_start_reg[lvl_idx] <= s_data.now_ticks;
                long_fired_reg[lvl_idx]  <= 1'b0;
            end
        end else if (state_reg == ST_EVAL) begin
            if (ev_long) begin
                long_fired_reg[key_cnt_reg] <= 1'b1;
            end
            if (ev_super) begin
                is_pressed_reg[key_cnt_reg] <= 1'b0;
            end
            if (!cur_pressed && cur_start_nz) begin
                press_start_reg[key_cnt_reg] <= '0;
            end
        end
    end

    // Checks
    `KPD_ASSERT_IMP(a_idle_no_pending, aclk, aresetn, state_reg == ST_IDLE, !ost.pend_valid)
    `KPD_ASSERT_IMP(a_short_exclusive, aclk, aresetn, state_reg == ST_EVAL, !(ev_short && (ev_long || ev_super)))
    `KPD_ASSERT_NXT(a_mvalid_source, aclk, aresetn, !m_valid && (state_reg != ST_EMIT) && (state_reg != ST_FLUSH), !m_valid)

endmodule

`default_nettype wire

/* dv/key_press_duration_classifier_top_test.sv */
// Self-checking testbench for the key press duration classifier top level.
module key_press_duration_classifier_top_test;

    import kpd_pkg::*;

    localparam int KEYS        = NUM_KEYS_DEF;
    localparam int SETTLE      = 40;        // also covers a scan that causes no events
    localparam int DRAIN_GUARD = 200000;
    localparam int HOLD_AT     = 110;       // request count that starts the long output hold
    localparam int HOLD_LEN    = 400;
    localparam int PAUSE_AT    = 150;       // request count after which the sender drains
    localparam int TIMEOUT     = 4000000;

    // Indexes past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // One line of the directed script: typed rows carry their own expectation
    typedef struct packed {
        logic     typed;
        logic     one_ev;
        kpd_out_t ev;
        kpd_in_t  item;
    } script_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    kpd_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    kpd_out_t              m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor copy of the registers and per-key state
    logic [TICK_W-1:0]    cfg_tick;
    logic [MS_W-1:0]      cfg_debounce;
    logic [MS_W-1:0]      cfg_short;
    logic [MS_W-1:0]      cfg_long;
    logic [MS_W-1:0]      cfg_super;
    logic [KEY_IDX_W-1:0] cfg_pwr;
    logic [DUR_W-1:0]     key_start [KEYS];
    logic                 key_held  [KEYS];
    logic                 long_sent [KEYS];

    kpd_out_t    scan_events [$];
    kpd_out_t    events_due  [$];
    script_row_t press_script [$];

    logic [DUR_W-1:0] cur_tick = '0;
    logic             pin_now [KEYS];
    int               items_sent = 0;
    int               mismatches = 0;
    bit               no_stall   = 1'b0;
    bit               hold_done  = 1'b0;

    always #4 aclk = ~aclk;

    key_press_duration_classifier_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Idle length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_stall || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic kpd_in_t lvl_chg(input int k, input logic lvl, input logic [DUR_W-1:0] t);
        kpd_in_t it;
        it.kind      = KIND_LEVEL;
        it.key_index = KEY_IDX_W'(k);
        it.pin_level = lvl;
        it.now_ticks = t;
        return it;
    endfunction

    // Key and level fields are don't-care on a scan, so fill them at random
    function automatic kpd_in_t scan_at(input logic [DUR_W-1:0] t);
        kpd_in_t it;
        it.kind      = KIND_SCAN;
        it.key_index = KEY_IDX_W'($urandom_range(0, 3));
        it.pin_level = 1'($urandom_range(0, 1));
        it.now_ticks = t;
        return it;
    endfunction

    function automatic script_row_t script_row(input kpd_in_t it, input int typed,
                                               input int one_ev, input int k,
                                               input logic [EVT_W-1:0] t);
        script_row_t r;
        r.item          = it;
        r.typed         = (typed != 0);
        r.one_ev        = (one_ev != 0);
        r.ev.event_key  = KEY_IDX_W'(k);
        r.ev.event_type = t;
        r.ev.last       = 1'b1;
        return r;
    endfunction

    function automatic void push_event(input int k, input logic [EVT_W-1:0] t);
        kpd_out_t ev;
        ev.event_key  = KEY_IDX_W'(k);
        ev.event_type = t;
        ev.last       = 1'b0;
        if (scan_events.size() < MAX_EVENTS) scan_events.push_back(ev);
    endfunction

    // Predict the events one request causes; leaves them in scan_events
    function automatic void classify_item(input kpd_in_t it);
        logic [DUR_W-1:0] dur;
        kpd_out_t         tail;
        scan_events.delete();
        if (it.kind == KIND_LEVEL) begin
            if (int'(it.key_index) < KEYS) begin
                key_held[it.key_index] = (it.pin_level == 1'b0);
                if (it.pin_level == 1'b0) begin
                    key_start[it.key_index] = it.now_ticks;
                    long_sent[it.key_index] = 1'b0;
                end
            end
        end else begin
            for (int k = 0; k < KEYS; k++) begin
                dur = (it.now_ticks - key_start[k]) * DUR_W'(cfg_tick);
                if (key_held[k]) begin
                    if (!long_sent[k] && dur >= DUR_W'(cfg_long)) begin
                        long_sent[k] = 1'b1;
                        push_event(k, EVT_LONG);
                    end
                    if (dur >= DUR_W'(cfg_super) && k == int'(cfg_pwr)) begin
                        push_event(k, EVT_SUPER);
                        key_held[k] = 1'b0;
                    end
                end else if (key_start[k] != '0) begin
                    // released key: short only inside the debounce..short window
                    if (dur >= DUR_W'(cfg_debounce) && dur < DUR_W'(cfg_short))
                        push_event(k, EVT_SHORT);
                    key_start[k] = '0;
                end
            end
            if (scan_events.size() > 0) begin
                tail      = scan_events.pop_back();
                tail.last = 1'b1;
                scan_events.push_back(tail);
            end
        end
    endfunction

    function automatic void flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("kpd check: %s", msg);
    endfunction

    // Offer one request on the input channel and hold it until accepted
    task automatic offer_item(input kpd_in_t it);
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic idle_sender();
        int g;
        g = idle_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // Wait for every due event, then for a scan that causes none to finish
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (events_due.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_TICK_PERIOD: cfg_tick     = val[TICK_W-1:0];
            REG_DEBOUNCE:    cfg_debounce = val[MS_W-1:0];
            REG_SHORT_MAX:   cfg_short    = val[MS_W-1:0];
            REG_LONG:        cfg_long     = val[MS_W-1:0];
            REG_SUPER_LONG:  cfg_super    = val[MS_W-1:0];
            REG_POWER_KEY:   cfg_pwr      = val[KEY_IDX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [15:0] tick, input logic [15:0] deb,
                                input logic [15:0] smax, input logic [15:0] lng,
                                input logic [15:0] sup, input logic [15:0] pwr,
                                input bit spare);
        wait_drained();
        write_reg(REG_TICK_PERIOD, tick);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_SHORT_MAX, smax);
        write_reg(REG_LONG, lng);
        write_reg(REG_SUPER_LONG, sup);
        write_reg(REG_POWER_KEY, pwr);
        if (spare) begin
            write_reg(REG_SPARE_LO, 16'hFFFF);
            write_reg(REG_SPARE_HI, 16'h0001);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random press/release traffic with scans; timestamps scaled to the thresholds
    task automatic run_random(input int n);
        int          r;
        int          k;
        int unsigned span;
        kpd_in_t     it;
        span = (int'(cfg_super) + int'(cfg_long)) / (cfg_tick == 0 ? 1 : int'(cfg_tick)) / 3 + 2;
        for (int i = 0; i < n; i++) begin
            cur_tick = cur_tick + $urandom_range(0, span);
            r = $urandom_range(0, 99);
            k = $urandom_range(0, KEYS - 1);
            if (r < 45) begin
                it = scan_at(cur_tick);
            end else if (r < 85) begin
                pin_now[k] = ~pin_now[k];
                it = lvl_chg(k, pin_now[k], cur_tick);
            end else if (r < 92) begin
                // repeated or stray level, not a clean toggle
                it = lvl_chg(k, 1'($urandom_range(0, 1)), cur_tick);
            end else if (r < 96) begin
                cur_tick = $urandom();
                it = scan_at(cur_tick);
            end else begin
                cur_tick = 32'hFFFF_FFFF - $urandom_range(0, span);
                it = scan_at(cur_tick);
            end
            offer_item(it);
            classify_item(it);
            foreach (scan_events[j]) events_due.push_back(scan_events[j]);
            if (items_sent == PAUSE_AT) begin
                s_valid <= 1'b0;
                while (events_due.size() != 0) @(posedge aclk);
            end else begin
                idle_sender();
            end
        end
    endtask

    // Output side: random back-pressure plus one long hold while requests keep coming
    initial begin : sink
        int g;
        wait (aresetn == 1'b1);
        forever begin
            @(posedge aclk);
            if (!hold_done && items_sent >= HOLD_AT) begin
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
                hold_done = 1'b1;
                m_ready <= 1'b1;
            end else begin
                g = idle_len();
                if (g > 0) begin
                    m_ready <= 1'b0;
                    repeat (g) @(posedge aclk);
                end
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted event with the oldest one due
    always @(posedge aclk) begin : out_check
        kpd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (events_due.size() == 0) begin
                flag_error($sformatf("unexpected event key %0d type %0d last %0d",
                                     m_data.event_key, m_data.event_type, m_data.last));
            end else begin
                want = events_due.pop_front();
                if (m_data.event_key !== want.event_key || m_data.event_type !== want.event_type ||
                    m_data.last !== want.last)
                    flag_error($sformatf(
                        "want key %0d type %0d last %0d, got key %0d type %0d last %0d",
                        want.event_key, want.event_type, want.last,
                        m_data.event_key, m_data.event_type, m_data.last));
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT);
        $display("key_press_duration_classifier_top: mismatch");
        $finish;
    end

    initial begin : stimulus
        script_row_t r;
        logic [15:0] lng_r;
        logic [15:0] tick_r;

        cfg_tick     = TICK_PERIOD_RST;
        cfg_debounce = DEBOUNCE_RST;
        cfg_short    = SHORT_MAX_RST;
        cfg_long     = LONG_RST;
        cfg_super    = SUPER_LONG_RST;
        cfg_pwr      = POWER_KEY_RST;
        for (int k = 0; k < KEYS; k++) begin
            key_start[k] = '0;
            key_held[k]  = 1'b0;
            long_sent[k] = 1'b0;
            pin_now[k]   = 1'b1;
        end

        // Directed script under reset register values
        press_script.push_back(script_row(scan_at(32'd0), 1, 0, 0, EVT_SHORT));
        press_script.push_back(script_row(scan_at(32'hFFFF_FFFF), 1, 0, 0, EVT_SHORT));
        press_script.push_back(script_row(lvl_chg(1, 1'b0, 32'd100), 1, 0, 0, EVT_SHORT));
        press_script.push_back(script_row(lvl_chg(1, 1'b1, 32'd110), 1, 0, 0, EVT_SHORT));
        press_script.push_back(script_row(scan_at(32'd120), 1, 1, 1, EVT_SHORT));
        press_script.push_back(script_row(scan_at(32'd130), 1, 0, 0, EVT_SHORT));
        press_script.push_back(script_row(lvl_chg(0, 1'b0, 32'd1000), 1, 0, 0, EVT_SHORT));
        press_script.push_back(script_row(scan_at(32'd1079), 1, 0, 0, EVT_SHORT));
        press_script.push_back(script_row(scan_at(32'd1080), 1, 1, 0, EVT_LONG));
        press_script.push_back(script_row(scan_at(32'd1199), 1, 0, 0, EVT_SHORT));
        press_script.push_back(script_row(scan_at(32'd1200), 1, 1, 0, EVT_SUPER));
        press_script.push_back(script_row(scan_at(32'd1201), 1, 0, 0, EVT_SHORT));
        press_script.push_back(script_row(lvl_chg(0, 1'b1, 32'd1300), 0, 0, 0, EVT_SHORT));
        // press stored at tick zero reads as idle once released
        press_script.push_back(script_row(lvl_chg(2, 1'b0, 32'd0), 0, 0, 0, EVT_SHORT));
        press_script.push_back(script_row(scan_at(32'd80), 0, 0, 0, EVT_SHORT));
        press_script.push_back(script_row(lvl_chg(2, 1'b1, 32'd90), 0, 0, 0, EVT_SHORT));
        press_script.push_back(script_row(scan_at(32'd91), 0, 0, 0, EVT_SHORT));
        // timestamp wrap across zero
        press_script.push_back(script_row(lvl_chg(3, 1'b0, 32'hFFFF_FFF0), 0, 0, 0, EVT_SHORT));
        press_script.push_back(script_row(lvl_chg(3, 1'b1, 32'h0000_0005), 0, 0, 0, EVT_SHORT));
        press_script.push_back(script_row(scan_at(32'h0000_0010), 0, 0, 0, EVT_SHORT));
        // all keys held: several events in one scan
        for (int k = 0; k < KEYS; k++)
            press_script.push_back(script_row(lvl_chg(k, 1'b0, 32'd5000), 0, 0, 0, EVT_SHORT));
        press_script.push_back(script_row(scan_at(32'd5200), 0, 0, 0, EVT_SHORT));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (press_script[i]) begin
            r = press_script[i];
            offer_item(r.item);
            classify_item(r.item);
            if (r.typed) begin
                if (r.one_ev) events_due.push_back(r.ev);
            end else begin
                foreach (scan_events[j]) events_due.push_back(scan_events[j]);
            end
            idle_sender();
        end
        cur_tick = 32'd6000;
        for (int k = 0; k < KEYS; k++) pin_now[k] = 1'b0;

        // Extreme settings
        program_regs(16'd1, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd3, 1'b1);
        run_random(20);
        program_regs(16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1, 1'b0);
        run_random(20);
        program_regs(16'd1000, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF, 16'd2, 1'b0);
        run_random(20);

        // Random settings; one phase with no idling on either side
        for (int p = 0; p < 4; p++) begin
            lng_r  = 16'($urandom_range(200, 3000));
            tick_r = (p == 3) ? 16'($urandom_range(1, 1000)) : 16'($urandom_range(1, 20));
            program_regs(tick_r, 16'($urandom_range(0, 100)), 16'($urandom_range(100, 1000)),
                         lng_r, 16'($urandom_range(lng_r, 6000)), 16'($urandom_range(0, 3)),
                         1'b0);
            no_stall = (p == 1);
            run_random(24);
        end
        no_stall = 1'b0;

        wait_drained();
        while (events_due.size() != 0) begin
            void'(events_due.pop_front());
            flag_error("event due but never produced");
        end
        if (mismatches == 0) begin
            $display("key_press_duration_classifier_top: match");
        end else begin
            $display("key_press_duration_classifier_top: mismatch");
        end
        $finish;
    end

endmodule
